// File: rtl/core/gzo_pkg.sv
package gzo_pkg;

   localparam int SAMPLE_W = 16;
   localparam int THR_W    = 10;
   localparam int LIMIT_W  = 8;
   localparam int RATE_W   = 18;
   localparam int DIFF_W   = SAMPLE_W + 1;

   // floor(m * 256 / 131) == (m * RATE_MULT) >> RATE_SHIFT for m < 2^16
   localparam int             RATE_MULT_W = 25;
   localparam logic [24:0]    RATE_MULT   = 25'd32786010;
   localparam int             RATE_SHIFT  = 24;
   localparam int             RATE_MAG_W  = 17;

   localparam logic [THR_W-1:0]   THR_RESET   = 10'd10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

   // register index, taken from paddr[2]
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_RUN_LIMIT = 1'b1;

   typedef struct packed {
      logic [THR_W-1:0]   still_threshold;
      logic [LIMIT_W-1:0] still_run_limit;
   } gzo_cfg_type;

   typedef struct packed {
      logic                       calibrating;
      logic                       last_cal;
      logic                       recalibrated;
      logic                       neg;
      logic [SAMPLE_W-1:0]        mag;
      logic signed [SAMPLE_W-1:0] offset;
   } gzo_item_type;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
      abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

endpackage

// File: rtl/core/gzo_csr.sv
module gzo_csr import gzo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output gzo_cfg_type       cfg
);

   logic [THR_W-1:0]   threshold_ff, threshold_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      limit_in     = limit_ff;
      if (wr_en) begin
         case (paddr[2])
            CSR_THRESHOLD: threshold_in = pwdata[THR_W-1:0];
            CSR_RUN_LIMIT: limit_in     = pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         limit_ff     <= limit_in;
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, threshold_ff};
         CSR_RUN_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, limit_ff};
         default:       prdata = 32'd0;
      endcase
   end

   assign cfg.still_threshold = threshold_ff;
   assign cfg.still_run_limit = limit_ff;

endmodule

// File: rtl/core/gzo_track.sv
module gzo_track import gzo_pkg::*; #(
   parameter int CAL_SAMPLES = 50
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  gzo_cfg_type                cfg,
   input  logic                       adv,
   output logic                       a_valid,
   output gzo_item_type               a_item
);

   localparam int CNT_W      = $clog2(CAL_SAMPLES + 1);
   localparam int SUM_W      = SAMPLE_W + $clog2(CAL_SAMPLES);
   localparam int MEAN_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
   localparam int MULT_W     = SUM_W + 2;
   localparam int PROD_W     = SUM_W + MULT_W;
   localparam logic [63:0] MEAN_POW = 64'd1 << MEAN_SHIFT;
   localparam logic [MULT_W-1:0] MEAN_MULT =
      MULT_W'((MEAN_POW + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_W-1:0] run_first_ff, run_first_in;
   logic [LIMIT_W-1:0]         still_cnt_ff, still_cnt_in;
   logic signed [SAMPLE_W-1:0] offset_ff, offset_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]           cal_cnt_ff, cal_cnt_in;
   logic                       pending_ff, pending_in;
   logic                       a_valid_ff, a_valid_in;
   gzo_item_type               a_item_ff, a_item_in;

   logic                       accept;
   logic                       cal_active;
   logic [CNT_W-1:0]           cal_cnt_inc;
   logic                       cal_last;
   logic signed [SUM_W-1:0]    sum_next;

   logic [DIFF_W-1:0]          dist_prev, dist_first;
   logic                       close_prev, far_first, hit;
   logic [LIMIT_W-1:0]         cnt_step;
   logic signed [DIFF_W-1:0]   rate_diff;

   logic [SUM_W-1:0]           sum_mag;
   logic [PROD_W-1:0]          mean_prod;
   logic [SAMPLE_W:0]          mean_mag;
   logic signed [SAMPLE_W-1:0] mean;

   assign req_ready = !pending_ff && (!a_valid_ff || adv);
   assign accept    = req_valid && req_ready;

   assign cal_active  = cal_cnt_ff < CNT_W'(CAL_SAMPLES);
   assign cal_cnt_inc = cal_cnt_ff + CNT_W'(1);
   assign cal_last    = cal_cnt_inc == CNT_W'(CAL_SAMPLES);
   assign sum_next    = sum_ff + SUM_W'(req_sample);

   // mean of the calibration sum, truncated toward zero; sum is final once used
   assign sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mean_prod = PROD_W'(sum_mag) * PROD_W'(MEAN_MULT);
   assign mean_mag  = mean_prod[MEAN_SHIFT +: SAMPLE_W+1];
   assign mean      = sum_ff[SUM_W-1] ? SAMPLE_W'((SAMPLE_W+1)'(0) - mean_mag)
                                      : mean_mag[SAMPLE_W-1:0];

   // still detection
   assign dist_prev  = abs_diff(DIFF_W'(req_sample) - DIFF_W'(prev_ff));
   assign dist_first = abs_diff(DIFF_W'(req_sample) - DIFF_W'(run_first_ff));
   assign close_prev = dist_prev <= DIFF_W'(cfg.still_threshold);
   // a run that starts here takes this sample as its first, so it cannot be far
   assign far_first  = (still_cnt_ff != '0) && (dist_first > DIFF_W'(cfg.still_threshold));
   assign cnt_step   = (close_prev && !far_first) ? still_cnt_ff + LIMIT_W'(1) : '0;
   assign hit        = cnt_step >= cfg.still_run_limit;
   assign rate_diff  = hit ? '0 : DIFF_W'(req_sample) - DIFF_W'(offset_ff);

   always_comb begin
      prev_in      = prev_ff;
      run_first_in = run_first_ff;
      still_cnt_in = still_cnt_ff;
      offset_in    = offset_ff;
      sum_in       = sum_ff;
      cal_cnt_in   = cal_cnt_ff;
      pending_in   = 1'b0;
      a_item_in    = a_item_ff;
      a_valid_in   = adv ? 1'b0 : a_valid_ff;

      if (pending_ff) begin
         offset_in    = mean;
         prev_in      = mean;
         run_first_in = mean;
      end

      if (accept) begin
         a_valid_in = 1'b1;
         if (cal_active) begin
            sum_in                 = sum_next;
            cal_cnt_in             = cal_cnt_inc;
            pending_in             = cal_last;
            a_item_in.calibrating  = 1'b1;
            a_item_in.last_cal     = cal_last;
            a_item_in.recalibrated = 1'b0;
            a_item_in.neg          = 1'b0;
            a_item_in.mag          = '0;
            a_item_in.offset       = offset_ff;
         end else begin
            prev_in = req_sample;
            if (close_prev && still_cnt_ff == '0) begin
               run_first_in = req_sample;
            end
            still_cnt_in = hit ? '0 : cnt_step;
            offset_in    = hit ? req_sample : offset_ff;
            a_item_in.calibrating  = 1'b0;
            a_item_in.last_cal     = 1'b0;
            a_item_in.recalibrated = hit;
            a_item_in.neg          = rate_diff[DIFF_W-1];
            a_item_in.mag          = SAMPLE_W'(abs_diff(rate_diff));
            a_item_in.offset       = hit ? req_sample : offset_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         run_first_ff <= '0;
         still_cnt_ff <= '0;
         offset_ff    <= '0;
         sum_ff       <= '0;
         cal_cnt_ff   <= '0;
         pending_ff   <= 1'b0;
         a_valid_ff   <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         run_first_ff <= run_first_in;
         still_cnt_ff <= still_cnt_in;
         offset_ff    <= offset_in;
         sum_ff       <= sum_in;
         cal_cnt_ff   <= cal_cnt_in;
         pending_ff   <= pending_in;
         a_valid_ff   <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff <= a_item_in;
   end

   assign a_valid = a_valid_ff;

   always_comb begin
      a_item = a_item_ff;
      if (a_item_ff.last_cal) begin
         a_item.offset = mean;
      end
   end

endmodule

// File: rtl/core/gzo_scale.sv
module gzo_scale import gzo_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       a_valid,
   input  gzo_item_type               a_item,
   output logic                       adv,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [RATE_W-1:0]   rsp_rate_q8,
   output logic signed [SAMPLE_W-1:0] rsp_zero_offset,
   output logic                       rsp_recalibrated,
   output logic                       rsp_calibrating
);

   localparam int PROD_W = SAMPLE_W + RATE_MULT_W;

   logic                       valid_ff, valid_in;
   logic signed [RATE_W-1:0]   rate_ff, rate_in;
   logic signed [SAMPLE_W-1:0] offset_ff;
   logic                       recal_ff, calib_ff;
   logic [PROD_W-1:0]          prod;
   logic [RATE_MAG_W-1:0]      quot;

   assign adv = !valid_ff || rsp_ready;

   // truncation toward zero: scale the magnitude, then restore the sign
   assign prod    = PROD_W'(a_item.mag) * PROD_W'(RATE_MULT);
   assign quot    = prod[RATE_SHIFT +: RATE_MAG_W];
   assign rate_in = a_item.neg ? RATE_W'(RATE_W'(0) - RATE_W'(quot)) : RATE_W'(quot);

   assign valid_in = adv ? a_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && a_valid) begin
         rate_ff   <= rate_in;
         offset_ff <= a_item.offset;
         recal_ff  <= a_item.recalibrated;
         calib_ff  <= a_item.calibrating;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_rate_q8      = rate_ff;
   assign rsp_zero_offset  = offset_ff;
   assign rsp_recalibrated = recal_ff;
   assign rsp_calibrating  = calib_ff;

endmodule

// File: rtl/core/gyro_zero_offset_tracker.sv
// Gyro zero-offset tracker: one signed 16-bit axis sample in, one corrected rate out.
// Input channel req_*: a transfer carries req_sample. Result channel rsp_*: each input
// transfer yields exactly one result transfer (rate in Q8 deg/s, offset in use, flags).
// Config port: APB-style, threshold at byte 0, run limit at byte 4; write while idle.
// A sample's result is registered in the tracking stage, then in the output register.
// Throughput: one sample per cycle while results are taken. The one exception is a single
// bubble on req_ready in the cycle after the last averaging sample, when the calibration
// mean is written into the offset, previous-sample and run-start registers.
// Two register stages: the tracking stage (state update, rate difference) and the
// scaling stage (constant multiply for *256/131), which is also the output register.
// When the receiver stalls, rsp_* holds; the tracking stage keeps taking one more
// sample, then req_ready drops until the output register drains.
// Reset (synchronous, active high) clears all tracking state and restarts averaging;
// config registers return to threshold 10 and run limit 100.
module gyro_zero_offset_tracker import gzo_pkg::*; #(
   parameter int CAL_SAMPLES = 50
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [RATE_W-1:0]   rsp_rate_q8,
   output logic signed [SAMPLE_W-1:0] rsp_zero_offset,
   output logic                       rsp_recalibrated,
   output logic                       rsp_calibrating,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   gzo_cfg_type  cfg;
   logic         adv;
   logic         a_valid;
   gzo_item_type a_item;

   // register file
   gzo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // averaging, still-run detection, offset replacement
   gzo_track #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .cfg        (cfg),
      .adv        (adv),
      .a_valid    (a_valid),
      .a_item     (a_item)
   );

   // rate scaling and output register
   gzo_scale u_scale (
      .clock            (clock),
      .reset            (reset),
      .a_valid          (a_valid),
      .a_item           (a_item),
      .adv              (adv),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rate_q8      (rsp_rate_q8),
      .rsp_zero_offset  (rsp_zero_offset),
      .rsp_recalibrated (rsp_recalibrated),
      .rsp_calibrating  (rsp_calibrating)
   );

`ifndef SYNTHESIS
   // averaging results carry no rate and never a recalibration
   a_calib_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> rsp_rate_q8 == '0 && !rsp_recalibrated)
      else $error("rate or recal flag set during calibration");

   // offset replaced by this very sample, so the corrected rate is zero
   a_recal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_recalibrated |-> rsp_rate_q8 == '0)
      else $error("nonzero rate on recalibration");

   // tracking stage holds its item while the scaling stage is blocked
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid && !adv |=> a_valid && $stable(a_item))
      else $error("tracking stage item lost under stall");
`endif

endmodule
